// ===== hdl/battery_voltage_supervisor_top_macros.svh =====
// ============================================================================
// Battery voltage supervisor assertion macros
// Shared concurrent assertion forms for the supervisor checker.
// ============================================================================
`ifndef BATTERY_VOLTAGE_SUPERVISOR_TOP_MACROS_SVH
`define BATTERY_VOLTAGE_SUPERVISOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held low
`define BVS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held low
`define BVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bvs_pkg.sv =====
// ============================================================================
// Battery voltage supervisor package
// Register indexes, reset values, status codes and the result layout.
// ============================================================================
`timescale 1ns / 1ps

package bvs_pkg;

    localparam int MV_W     = 16;
    localparam int Q_W      = MV_W + 2;
    localparam int CNT_W    = 8;
    localparam int CODE_W   = 3;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MONITOR_ENABLED       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD_MV      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT_MV         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BROWNOUT_THRESHOLD_MV = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_RECOVERY_MV       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BROWNOUT_RECOVERY_MV  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_DEBOUNCE_COUNT    = 3'd6;

    // Register reset values
    localparam logic [MV_W-1:0]  RST_HIGH_LIMIT_MV        = 16'd65535;
    localparam logic [MV_W-1:0]  RST_LOW_RECOVERY_MV      = 16'd300;
    localparam logic [MV_W-1:0]  RST_BROWNOUT_RECOVERY_MV = 16'd500;
    localparam logic [CNT_W-1:0] RST_LOW_DEBOUNCE_COUNT   = 8'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

    // Status codes
    localparam logic [CODE_W-1:0] ST_OK           = 3'd0;
    localparam logic [CODE_W-1:0] ST_NOT_CFG      = 3'd1;
    localparam logic [CODE_W-1:0] ST_UNAVAILABLE  = 3'd2;
    localparam logic [CODE_W-1:0] ST_BROWNOUT     = 3'd3;
    localparam logic [CODE_W-1:0] ST_LOW          = 3'd4;
    localparam logic [CODE_W-1:0] ST_OUT_OF_RANGE = 3'd5;

    // Result item as packed on the output tdata, last member in bit 0
    typedef struct packed {
        logic              pad;
        logic [CNT_W-1:0]  unavailable_count;
        logic [CODE_W-1:0] status_code;
        logic [MV_W-1:0]   filtered_mv;
        logic              low_battery;
        logic              brownout;
        logic              healthy;
        logic              configured;
    } t_result;

endpackage

// ===== hdl/battery_voltage_supervisor_top.sv =====
// ============================================================================
// Battery voltage supervisor
// Quarter-weight averaging of battery samples with brownout, debounced
// low-voltage and over-range checks; one status per sample.
// ============================================================================
//
// Channel  | Dir | Handshake                      | Payload
// ---------+-----+--------------------------------+------------------------------
// sample   | in  | s_axis_tvalid / s_axis_tready  | tdata: sample_mv, tuser: sample_valid
// status   | out | m_axis_tvalid / m_axis_tready  | tdata: result fields (see port)
// config   | in  | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// Status is produced through two registers: the input register, then the result
// register. One sample per cycle is sustained while the output is not stalled; the
// filter and compare path between the two registers is combinational.
// Reset is synchronous, active low; it clears state and valid flags and loads config defaults.
// A stalled output holds its result; the input register still takes one more
// sample, then s_axis_tready drops until the result is taken.
`timescale 1ns / 1ps

module battery_voltage_supervisor_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_mv
    input  logic        s_axis_tuser,   // [0] sample_valid
    // status stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] configured, [1] healthy, [2] brownout, [3] low_battery,
    // [19:4] filtered_mv, [22:20] status_code, [30:23] unavailable_count, [31] zero
    output logic [31:0] m_axis_tdata,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int MV_W  = bvs_pkg::MV_W;
    localparam int Q_W   = bvs_pkg::Q_W;
    localparam int CNT_W = bvs_pkg::CNT_W;

    // configuration registers
    logic             r_enabled;
    logic [MV_W-1:0]  r_low_thr;
    logic [MV_W-1:0]  r_high_lim;
    logic [MV_W-1:0]  r_bo_thr;
    logic [MV_W-1:0]  r_low_rec;
    logic [MV_W-1:0]  r_bo_rec;
    logic [CNT_W-1:0] r_debounce;

    // supervisor state
    logic [Q_W-1:0]   r_q,        n_q;
    logic             r_started,  n_started;
    logic             r_low_latch, n_low_latch;
    logic             r_bo_latch, n_bo_latch;
    logic [CNT_W-1:0] r_low_cnt,  n_low_cnt;
    logic [CNT_W-1:0] r_miss_cnt, n_miss_cnt;

    // pipeline registers
    logic             r_in_valid;
    logic             r_in_flag;
    logic [MV_W-1:0]  r_in_mv;
    logic             r_out_valid;
    bvs_pkg::t_result r_out, n_out;

    logic advance;

    // move the held sample into the result register when that slot is free
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;
    assign o_cfg_ready   = 1'b1;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= 1'b0;
            r_low_thr  <= '0;
            r_high_lim <= bvs_pkg::RST_HIGH_LIMIT_MV;
            r_bo_thr   <= '0;
            r_low_rec  <= bvs_pkg::RST_LOW_RECOVERY_MV;
            r_bo_rec   <= bvs_pkg::RST_BROWNOUT_RECOVERY_MV;
            r_debounce <= bvs_pkg::RST_LOW_DEBOUNCE_COUNT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bvs_pkg::REG_MONITOR_ENABLED:       r_enabled  <= i_cfg_data[0];
                bvs_pkg::REG_LOW_THRESHOLD_MV:      r_low_thr  <= i_cfg_data;
                bvs_pkg::REG_HIGH_LIMIT_MV:         r_high_lim <= i_cfg_data;
                bvs_pkg::REG_BROWNOUT_THRESHOLD_MV: r_bo_thr   <= i_cfg_data;
                bvs_pkg::REG_LOW_RECOVERY_MV:       r_low_rec  <= i_cfg_data;
                bvs_pkg::REG_BROWNOUT_RECOVERY_MV:  r_bo_rec   <= i_cfg_data;
                bvs_pkg::REG_LOW_DEBOUNCE_COUNT:    r_debounce <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // filter and checks for the held sample
    logic signed [Q_W:0] diff;
    logic signed [Q_W:0] step;
    logic [Q_W-1:0]      q_upd;
    logic [MV_W:0]       bo_sum;
    logic [MV_W:0]       low_sum;
    logic                bo_now;
    logic                low_now;

    always_comb begin
        diff    = $signed({1'b0, r_in_mv, 2'b00}) - $signed({1'b0, r_q});
        step    = diff >>> 2;
        q_upd   = r_started ? Q_W'(r_q + step[Q_W-1:0]) : {r_in_mv, 2'b00};
        bo_sum  = {1'b0, r_bo_thr} + {1'b0, r_bo_rec};
        low_sum = {1'b0, r_low_thr} + {1'b0, r_low_rec};

        bo_now = (r_bo_thr != '0) &&
                 ((q_upd < {r_bo_thr, 2'b00}) ||
                  (r_bo_latch && ({1'b0, q_upd} < {bo_sum, 2'b00})));
        low_now = (q_upd < {r_low_thr, 2'b00}) ||
                  (r_low_latch && ({1'b0, q_upd} < {low_sum, 2'b00}));

        n_q         = r_q;
        n_started   = r_started;
        n_low_latch = r_low_latch;
        n_bo_latch  = r_bo_latch;
        n_low_cnt   = r_low_cnt;
        n_miss_cnt  = r_miss_cnt;

        n_out                   = '0;
        n_out.configured        = 1'b1;
        n_out.filtered_mv       = q_upd[Q_W-1:2];
        n_out.status_code       = bvs_pkg::ST_OK;

        priority if (!r_enabled) begin
            n_out.configured  = 1'b0;
            n_out.filtered_mv = '0;
            n_out.status_code = bvs_pkg::ST_NOT_CFG;
        end else if (!r_in_flag) begin
            if (r_miss_cnt != bvs_pkg::CNT_MAX) begin
                n_miss_cnt = r_miss_cnt + 1'b1;
            end
            n_out.filtered_mv = '0;
            n_out.status_code = bvs_pkg::ST_UNAVAILABLE;
        end else begin
            n_miss_cnt = '0;
            n_q        = q_upd;
            n_started  = 1'b1;
            if (bo_now) begin
                n_low_latch       = 1'b1;
                n_bo_latch        = 1'b1;
                n_out.brownout    = 1'b1;
                n_out.low_battery = 1'b1;
                n_out.status_code = bvs_pkg::ST_BROWNOUT;
            end else begin
                n_bo_latch = 1'b0;
                if (low_now) begin
                    if (r_low_cnt != bvs_pkg::CNT_MAX) begin
                        n_low_cnt = r_low_cnt + 1'b1;
                    end
                end else begin
                    n_low_cnt = '0;
                end
                if (low_now && (r_low_latch || (n_low_cnt >= r_debounce))) begin
                    n_low_latch       = 1'b1;
                    n_out.low_battery = 1'b1;
                    n_out.status_code = bvs_pkg::ST_LOW;
                end else begin
                    n_low_latch = 1'b0;
                    if (q_upd > {r_high_lim, 2'b00}) begin
                        n_out.status_code = bvs_pkg::ST_OUT_OF_RANGE;
                    end else begin
                        n_out.healthy = 1'b1;
                    end
                end
            end
        end
        n_out.unavailable_count = n_miss_cnt;
    end

    // advance input register, result register and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_q         <= '0;
            r_started   <= 1'b0;
            r_low_latch <= 1'b0;
            r_bo_latch  <= 1'b0;
            r_low_cnt   <= '0;
            r_miss_cnt  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (advance && r_in_valid) begin
                r_q         <= n_q;
                r_started   <= n_started;
                r_low_latch <= n_low_latch;
                r_bo_latch  <= n_bo_latch;
                r_low_cnt   <= n_low_cnt;
                r_miss_cnt  <= n_miss_cnt;
            end
        end
    end

    // hold payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_flag <= s_axis_tuser;
            r_in_mv   <= s_axis_tdata;
        end
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== hdl/bvs_checker.sv =====
// ============================================================================
// Battery voltage supervisor checker
// Port-level assertions on the status stream, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`include "battery_voltage_supervisor_top_macros.svh"

module bvs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    bvs_pkg::t_result res;
    assign res = m_axis_tdata;

    // a stalled result holds until taken
    `BVS_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled status changed")

    // healthy is set exactly for the ok status
    `BVS_ASSERT_NOW(a_healthy_ok, i_clk, i_rst_n, m_axis_tvalid, res.healthy == (res.status_code == bvs_pkg::ST_OK), "healthy does not match status")

    // brownout is reported with low battery and its own code
    `BVS_ASSERT_NOW(a_brownout_low, i_clk, i_rst_n, m_axis_tvalid && res.brownout, res.low_battery && (res.status_code == bvs_pkg::ST_BROWNOUT), "brownout without low flag or code")

    // not configured and unavailable report no voltage
    `BVS_ASSERT_NOW(a_no_voltage, i_clk, i_rst_n, m_axis_tvalid && ((res.status_code == bvs_pkg::ST_NOT_CFG) || (res.status_code == bvs_pkg::ST_UNAVAILABLE)), (res.filtered_mv == '0) && !res.low_battery && (res.configured == (res.status_code == bvs_pkg::ST_UNAVAILABLE)), "voltage or flags on a missing sample")

endmodule

bind battery_voltage_supervisor_top bvs_checker u_bvs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
